### src/vnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_pkg
// Shared types and constants for the vertex and normal transform pipeline.
// ----------------------------------------------------------------------------
package vnt_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int NRM_W   = 16;
    localparam int COEF_W  = 16;
    localparam int REG_W   = 48;
    localparam int DATA_W  = 144;

    // Register indexes
    typedef enum logic [1:0] {
        REG_COL0  = 2'd0,
        REG_COL1  = 2'd1,
        REG_COL2  = 2'd2,
        REG_SHIFT = 2'd3
    } reg_idx_t;

    localparam logic [REG_W-1:0] COL0_RST  = 48'h0000_0000_1000;
    localparam logic [REG_W-1:0] COL1_RST  = 48'h0000_1000_0000;
    localparam logic [REG_W-1:0] COL2_RST  = 48'h1000_0000_0000;
    localparam logic [REG_W-1:0] SHIFT_RST = 48'h0;

    // Pipeline stage map
    localparam int ST_PROD    = 0;   // products
    localparam int ST_SUM     = 1;   // row sums
    localparam int ST_RND     = 2;   // position round, normal magnitudes
    localparam int ST_MSB     = 3;   // leading one of largest magnitude
    localparam int ST_SHF     = 4;   // common normalising shift
    localparam int ST_SQR     = 5;   // squares
    localparam int ST_ACC     = 6;   // sum of squares
    localparam int SQ_STAGES  = 16;  // two root bits per stage
    localparam int ST_SQ0     = ST_ACC + 1;
    localparam int ST_DIVI    = ST_SQ0 + SQ_STAGES;
    localparam int DV_STAGES  = 8;   // two quotient bits per stage
    localparam int ST_DV0     = ST_DIVI + 1;
    localparam int ST_OUT     = ST_DV0 + DV_STAGES;
    localparam int NS         = ST_OUT + 1;

    // Payload carried through the pipeline
    typedef struct {
        logic signed [47:0] pp [9];
        logic signed [31:0] np [9];
        logic signed [49:0] pacc [3];
        logic signed [33:0] nr [3];
        logic signed [31:0] opos [3];
        logic        [31:0] mag [3];
        logic        [2:0]  neg;
        logic        [31:0] maxm;
        logic               zero;
        logic        [4:0]  msb;
        logic        [30:0] smag [3];
        logic        [61:0] sq [3];
        logic        [63:0] sx;
        logic        [35:0] srem;
        logic        [31:0] root;
        logic        [15:0] dlow [3];
        logic        [33:0] drem [3];
        logic        [15:0] dq [3];
        logic        [15:0] onrm [3];
        logic        [15:0] innrm [3];
        logic               eom;
    } vx_t;

endpackage

### src/vertex_normal_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_transform_top
// Position through a 3x4 matrix with saturation; normal through the 3x3 part,
// then scaled to unit length by a pipelined square root and divider.
// ----------------------------------------------------------------------------
// Usage:
//  - Input items arrive on s_tvalid/s_tready/s_tdata, with the end-of-mesh
//    flag on s_tlast. Results leave on m_tvalid/m_tready/m_tdata, with
//    end-of-mesh on m_tlast and the kept-normal flag on m_tuser.
//  - The matrix is loaded through cfg_wr_en/cfg_index/cfg_data. The user must
//    do so only while no item is in flight; the block does not enforce it.
//    Reset loads the identity with no translation.
//  - The pipeline has 33 register stages, the first loaded at acceptance.
//  - Throughput is one item per cycle: every stage is a single register
//    stage, the square root retires two bits per stage over 16 stages and
//    the three dividers two quotient bits per stage over 8 stages.
//  - When the receiver stalls with a result waiting, the whole pipeline
//    holds and s_tready drops; nothing is lost or repeated. Empty slots
//    pass through as bubbles.
//  - Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_normal_transform_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z
    input  logic [vnt_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
    output logic [vnt_pkg::DATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    // normal_kept
    output logic                       m_tuser,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [vnt_pkg::REG_W-1:0]  cfg_data
);
    import vnt_pkg::*;

    logic [REG_W-1:0] col0_reg, col1_reg, col2_reg, shift_reg;
    vx_t              st_reg  [NS];
    vx_t              st_next [NS];
    logic [NS-1:0]    vld_reg;
    logic             adv;

    // Matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col0_reg  <= COL0_RST;
            col1_reg  <= COL1_RST;
            col2_reg  <= COL2_RST;
            shift_reg <= SHIFT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_COL0:  col0_reg  <= cfg_data;
                REG_COL1:  col1_reg  <= cfg_data;
                REG_COL2:  col2_reg  <= cfg_data;
                REG_SHIFT: shift_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output item is held
    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // Products of coefficients with position and normal
    always_comb
    begin
        logic signed [15:0] c;
        logic signed [31:0] p [3];
        logic signed [15:0] n [3];
        st_next[ST_PROD] = '{default: '0};
        for (int j = 0; j < 3; j++)
        begin
            p[j] = $signed(s_tdata[32*j +: 32]);
            n[j] = $signed(s_tdata[96 + 16*j +: 16]);
            st_next[ST_PROD].innrm[j] = s_tdata[96 + 16*j +: 16];
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                unique case (j)
                    0:       c = $signed(col0_reg[16*k +: 16]);
                    1:       c = $signed(col1_reg[16*k +: 16]);
                    default: c = $signed(col2_reg[16*k +: 16]);
                endcase
                st_next[ST_PROD].pp[3*k+j] = 48'(c) * 48'(p[j]);
                st_next[ST_PROD].np[3*k+j] = 32'(c) * 32'(n[j]);
            end
        end
        st_next[ST_PROD].eom = s_tlast;
    end

    // Row sums with translation
    always_comb
    begin
        logic signed [15:0] t;
        st_next[ST_SUM] = st_reg[ST_SUM-1];
        for (int k = 0; k < 3; k++)
        begin
            t = $signed(shift_reg[16*k +: 16]);
            st_next[ST_SUM].pacc[k] = 50'(st_reg[ST_SUM-1].pp[3*k])
                                    + 50'(st_reg[ST_SUM-1].pp[3*k+1])
                                    + 50'(st_reg[ST_SUM-1].pp[3*k+2])
                                    + (50'(t) <<< 16);
            st_next[ST_SUM].nr[k] = 34'(st_reg[ST_SUM-1].np[3*k])
                                  + 34'(st_reg[ST_SUM-1].np[3*k+1])
                                  + 34'(st_reg[ST_SUM-1].np[3*k+2]);
        end
    end

    // Round and saturate positions; take normal magnitudes
    always_comb
    begin
        logic signed [50:0] rnd;
        logic signed [38:0] fl;
        logic        [33:0] a;
        st_next[ST_RND] = st_reg[ST_RND-1];
        for (int k = 0; k < 3; k++)
        begin
            rnd = 51'(st_reg[ST_RND-1].pacc[k]) + 51'sd2048;
            fl  = 39'(rnd >>> 12);
            if (fl > 39'sd2147483647)
                st_next[ST_RND].opos[k] = 32'h7FFF_FFFF;
            else if (fl < -39'sd2147483648)
                st_next[ST_RND].opos[k] = 32'h8000_0000;
            else
                st_next[ST_RND].opos[k] = fl[31:0];
            st_next[ST_RND].neg[k] = st_reg[ST_RND-1].nr[k][33];
            a = st_reg[ST_RND-1].nr[k][33] ? 34'(-st_reg[ST_RND-1].nr[k])
                                            : st_reg[ST_RND-1].nr[k];
            st_next[ST_RND].mag[k] = a[31:0];
        end
        st_next[ST_RND].maxm = st_next[ST_RND].mag[0];
        if (st_next[ST_RND].mag[1] > st_next[ST_RND].maxm)
            st_next[ST_RND].maxm = st_next[ST_RND].mag[1];
        if (st_next[ST_RND].mag[2] > st_next[ST_RND].maxm)
            st_next[ST_RND].maxm = st_next[ST_RND].mag[2];
        st_next[ST_RND].zero = (st_next[ST_RND].maxm == '0);
    end

    // Find the leading one of the largest magnitude
    always_comb
    begin
        st_next[ST_MSB]     = st_reg[ST_MSB-1];
        st_next[ST_MSB].msb = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (st_reg[ST_MSB-1].maxm[i])
                st_next[ST_MSB].msb = 5'(i);
        end
    end

    // Shift all magnitudes so the largest sits in [2^30, 2^31)
    always_comb
    begin
        logic [31:0] sh;
        st_next[ST_SHF] = st_reg[ST_SHF-1];
        for (int k = 0; k < 3; k++)
        begin
            if (st_reg[ST_SHF-1].msb == 5'd31)
                sh = st_reg[ST_SHF-1].mag[k] >> 1;
            else
                sh = st_reg[ST_SHF-1].mag[k] << (5'd30 - st_reg[ST_SHF-1].msb);
            st_next[ST_SHF].smag[k] = sh[30:0];
        end
    end

    // Squares
    always_comb
    begin
        st_next[ST_SQR] = st_reg[ST_SQR-1];
        for (int k = 0; k < 3; k++)
            st_next[ST_SQR].sq[k] = 62'(st_reg[ST_SQR-1].smag[k])
                                  * 62'(st_reg[ST_SQR-1].smag[k]);
    end

    // Sum of squares; load the root unit
    always_comb
    begin
        st_next[ST_ACC]      = st_reg[ST_ACC-1];
        st_next[ST_ACC].sx   = 64'(st_reg[ST_ACC-1].sq[0])
                             + 64'(st_reg[ST_ACC-1].sq[1])
                             + 64'(st_reg[ST_ACC-1].sq[2]);
        st_next[ST_ACC].srem = '0;
        st_next[ST_ACC].root = '0;
    end

    // Square root, two result bits per stage
    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sqrt
        always_comb
        begin
            logic [35:0] r2;
            logic [33:0] trial;
            st_next[ST_SQ0+g] = st_reg[ST_SQ0+g-1];
            for (int s = 0; s < 2; s++)
            begin
                r2    = {st_next[ST_SQ0+g].srem[33:0], st_next[ST_SQ0+g].sx[63:62]};
                trial = {st_next[ST_SQ0+g].root, 2'b01};
                st_next[ST_SQ0+g].sx = st_next[ST_SQ0+g].sx << 2;
                if (r2 >= 36'(trial))
                begin
                    st_next[ST_SQ0+g].srem = r2 - 36'(trial);
                    st_next[ST_SQ0+g].root = {st_next[ST_SQ0+g].root[30:0], 1'b1};
                end
                else
                begin
                    st_next[ST_SQ0+g].srem = r2;
                    st_next[ST_SQ0+g].root = {st_next[ST_SQ0+g].root[30:0], 1'b0};
                end
            end
        end
    end

    // Load the dividers: (mag * 2^15 + len) / (2 * len)
    always_comb
    begin
        logic [46:0] num;
        st_next[ST_DIVI] = st_reg[ST_DIVI-1];
        for (int k = 0; k < 3; k++)
        begin
            num = (47'(st_reg[ST_DIVI-1].smag[k]) << 15) + 47'(st_reg[ST_DIVI-1].root);
            st_next[ST_DIVI].drem[k] = 34'(num[46:16]);
            st_next[ST_DIVI].dlow[k] = num[15:0];
            st_next[ST_DIVI].dq[k]   = '0;
        end
    end

    // Restoring division, two quotient bits per stage
    for (genvar g = 0; g < DV_STAGES; g++)
    begin : g_div
        always_comb
        begin
            logic [33:0] r2;
            logic [33:0] den;
            st_next[ST_DV0+g] = st_reg[ST_DV0+g-1];
            den = {1'b0, st_reg[ST_DV0+g-1].root, 1'b0};
            for (int k = 0; k < 3; k++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    r2 = {st_next[ST_DV0+g].drem[k][32:0], st_next[ST_DV0+g].dlow[k][15]};
                    st_next[ST_DV0+g].dlow[k] = st_next[ST_DV0+g].dlow[k] << 1;
                    if (r2 >= den)
                    begin
                        st_next[ST_DV0+g].drem[k] = r2 - den;
                        st_next[ST_DV0+g].dq[k]   = {st_next[ST_DV0+g].dq[k][14:0], 1'b1};
                    end
                    else
                    begin
                        st_next[ST_DV0+g].drem[k] = r2;
                        st_next[ST_DV0+g].dq[k]   = {st_next[ST_DV0+g].dq[k][14:0], 1'b0};
                    end
                end
            end
        end
    end

    // Clamp, apply sign, or keep the input normal
    always_comb
    begin
        logic        [15:0] qc;
        logic signed [16:0] v;
        st_next[ST_OUT] = st_reg[ST_OUT-1];
        for (int k = 0; k < 3; k++)
        begin
            qc = (st_reg[ST_OUT-1].dq[k] > 16'd32768) ? 16'd32768
                                                       : st_reg[ST_OUT-1].dq[k];
            v  = st_reg[ST_OUT-1].neg[k] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
            if (v > 17'sd32767)
                v = 17'sd32767;
            if (st_reg[ST_OUT-1].zero)
                st_next[ST_OUT].onrm[k] = st_reg[ST_OUT-1].innrm[k];
            else
                st_next[ST_OUT].onrm[k] = v[15:0];
        end
    end

    // Output item
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {st_reg[ST_OUT].onrm[2], st_reg[ST_OUT].onrm[1],
                       st_reg[ST_OUT].onrm[0], st_reg[ST_OUT].opos[2],
                       st_reg[ST_OUT].opos[1], st_reg[ST_OUT].opos[0]};
    assign m_tlast  = st_reg[ST_OUT].eom;
    assign m_tuser  = st_reg[ST_OUT].zero;

    // An accepted item enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> vld_reg[ST_PROD])
        else $error("accepted item did not enter the pipeline");

    // A non-zero normal yields a root of at least 2^30
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIVI] && !st_reg[ST_DIVI].zero |-> st_reg[ST_DIVI].root[31:30] != 2'b00)
        else $error("root out of range after normalising shift");

    // A rescaled normal is never all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[143:96] != 48'h0)
        else $error("unit normal collapsed to zero");

    // Quotients stay within a unit length
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT-1] && !st_reg[ST_OUT-1].zero |->
            st_reg[ST_OUT-1].dq[0] <= 16'd16384 && st_reg[ST_OUT-1].dq[1] <= 16'd16384
            && st_reg[ST_OUT-1].dq[2] <= 16'd16384)
        else $error("normal quotient above one");

endmodule

### tb/sv/vertex_normal_transform_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_transform_top_test
// Streams vertices through the transform and compares every result against
// a fixed-point predictor of the position matrix product and normal
// renormalisation, under several matrix settings and idling patterns.
// ----------------------------------------------------------------------------
module vertex_normal_transform_top_test;
    import vnt_pkg::*;

    typedef struct packed {
        logic        eom;
        logic        kept;
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
    } vertex_res_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [REG_W-1:0]    cfg_data;

    // Predictor copy of the matrix registers
    logic [REG_W-1:0]    mat_reg [4];

    vertex_res_t         expected_vertices [$];
    int                  mismatch_count;
    int                  sent_count;
    int                  result_count;
    int                  kept_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    vertex_normal_transform_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("Timeout with %0d results outstanding", expected_vertices.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint coef(input logic [REG_W-1:0] r, input int k);
        logic signed [15:0] c;
        c = r[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x  -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Transform one vertex: position with rounding and saturation, normal to unit
    function automatic vertex_res_t transform_vertex(input logic [DATA_W-1:0] d,
                                                     input logic eom);
        vertex_res_t     res;
        longint          p [3];
        longint          n [3];
        longint          r [3];
        longint          acc;
        longint          rnd;
        longint unsigned mag [3];
        longint unsigned maxm;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        longint          v;
        logic [31:0]     pv [3];
        logic [15:0]     nv [3];
        for (int k = 0; k < 3; k++)
        begin
            p[k] = longint'($signed(d[32*k +: 32]));
            n[k] = longint'($signed(d[96 + 16*k +: 16]));
        end
        maxm = 0;
        for (int k = 0; k < 3; k++)
        begin
            acc = coef(mat_reg[REG_COL0], k) * p[0] + coef(mat_reg[REG_COL1], k) * p[1]
                + coef(mat_reg[REG_COL2], k) * p[2] + coef(mat_reg[REG_SHIFT], k) * 65536;
            rnd = (acc + 2048) >>> 12;
            if (rnd > 64'sd2147483647)
                rnd = 64'sd2147483647;
            else if (rnd < -64'sd2147483648)
                rnd = -64'sd2147483648;
            pv[k] = rnd[31:0];
            r[k] = coef(mat_reg[REG_COL0], k) * n[0] + coef(mat_reg[REG_COL1], k) * n[1]
                 + coef(mat_reg[REG_COL2], k) * n[2];
            mag[k] = (r[k] < 0) ? longint'(-r[k]) : longint'(r[k]);
            if (mag[k] > maxm)
                maxm = mag[k];
        end
        res.kept = (maxm == 0);
        if (maxm == 0)
        begin
            for (int k = 0; k < 3; k++)
                nv[k] = d[96 + 16*k +: 16];
        end
        else
        begin
            while (maxm >= (64'd1 << 31))
            begin
                maxm >>= 1;
                for (int k = 0; k < 3; k++)
                    mag[k] >>= 1;
            end
            while (maxm < (64'd1 << 30))
            begin
                maxm <<= 1;
                for (int k = 0; k < 3; k++)
                    mag[k] <<= 1;
            end
            sum = 0;
            for (int k = 0; k < 3; k++)
                sum += mag[k] * mag[k];
            len = int_sqrt(sum);
            for (int k = 0; k < 3; k++)
            begin
                q = ((mag[k] << 15) + len) / (2 * len);
                if (q > 32768)
                    q = 32768;
                v = (r[k] < 0) ? -longint'(q) : longint'(q);
                if (v > 32767)
                    v = 32767;
                nv[k] = v[15:0];
            end
        end
        res.px  = pv[0];
        res.py  = pv[1];
        res.pz  = pv[2];
        res.nx  = nv[0];
        res.ny  = nv[1];
        res.nz  = nv[2];
        res.eom = eom;
        return res;
    endfunction

    // Send one vertex, idling beforehand at the current rate
    task automatic send_vertex(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz, input logic [15:0] nx,
                               input logic [15:0] ny, input logic [15:0] nz,
                               input logic eom);
        logic [DATA_W-1:0] d;
        d = {nz, ny, nx, pz, py, px};
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eom;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_vertices.push_back(transform_vertex(d, eom));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold until every expected result has drained, then idle with valid low
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mat_reg[idx] = val;
    endtask

    task automatic load_matrix(input logic [REG_W-1:0] c0, input logic [REG_W-1:0] c1,
                               input logic [REG_W-1:0] c2, input logic [REG_W-1:0] sh);
        drain();
        write_reg(REG_COL0, c0);
        write_reg(REG_COL1, c1);
        write_reg(REG_COL2, c2);
        write_reg(REG_SHIFT, sh);
    endtask

    function automatic logic [15:0] rand_nrm();
        case ($urandom_range(3, 0))
            0:       return 16'($urandom_range(32767, 0)) - 16'd16384;
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(2, 0)) - 16'd1;
            default: return ($urandom_range(1, 0) != 0) ? 16'h8000 : 16'h7fff;
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3, 0))
            0:       return 32'($urandom_range(2097152, 0)) - 32'd1048576;
            1:       return $urandom;
            2:       return ($urandom_range(1, 0) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($urandom_range(8, 0)) - 32'd4;
        endcase
    endfunction

    function automatic logic [REG_W-1:0] rand_col();
        logic [REG_W-1:0] c;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(3, 0))
                0:       c[16*k +: 16] = 16'($urandom_range(8192, 0)) - 16'd4096;
                1:       c[16*k +: 16] = 16'($urandom);
                2:       c[16*k +: 16] = 16'h0;
                default: c[16*k +: 16] = ($urandom_range(1, 0) != 0) ? 16'h8000 : 16'h7fff;
            endcase
        end
        return c;
    endfunction

    // Directed corners: field extremes, zero normal, saturation, mesh flag
    task automatic test_directed();
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 16'h4000, 16'h0, 16'h0, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_vertex(32'hffff_ffff, 32'h1, 32'h0, 16'hffff, 16'h1, 16'h0, 1'b0);
        send_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                    16'h5555, 16'haaaa, 16'h0f0f, 1'b1);
        drop_valid();
        // Largest coefficients with full translation: positions saturate
        load_matrix(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
                    48'h7fff_7fff_7fff);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    16'h7fff, 16'h0, 16'h0, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_vertex(32'h8000_0000, 32'h1234_5678, 32'h0, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        load_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                    48'h8000_8000_8000);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1, 16'h7fff, 16'h8000, 16'h1, 1'b1);
        // Singular matrix: every normal transforms to zero and is kept
        load_matrix(48'h0, 48'h0, 48'h0, 48'h0001_ffff_0800);
        send_vertex(32'h0001_0000, 32'h0, 32'h0, 16'h1234, 16'hfedc, 16'h0, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0, 16'h8000, 16'h7fff, 16'h0001, 1'b1);
        // Cancelling columns: a nonzero normal maps to zero
        load_matrix(48'h0000_0000_1000, 48'h0000_0000_1000, 48'h0, 48'h0);
        send_vertex(32'h0000_0800, 32'h0000_0800, 32'h0, 16'h2000, 16'he000, 16'h3000, 1'b0);
        send_vertex(32'h0000_0800, 32'h0000_0800, 32'h0, 16'h2000, 16'h2000, 16'h0, 1'b0);
        drop_valid();
    endtask

    task automatic test_random_phase(input int n_vertices, input int idle_pct,
                                     input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_matrix(rand_col(), rand_col(), rand_col(), rand_col());
        for (int i = 0; i < n_vertices; i++)
            send_vertex(rand_pos(), rand_pos(), rand_pos(), rand_nrm(), rand_nrm(),
                        rand_nrm(), 1'($urandom_range(7, 0) == 0));
        drop_valid();
    endtask

    // Receiver back-pressure; hold ready low during reset
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        else
            m_tready <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        vertex_res_t got;
        vertex_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tuser, m_tdata};
            result_count++;
            if (expected_vertices.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %h", got);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (want.kept)
                    kept_count++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Mismatch: pos %h %h %h nrm %h %h %h kept %b eom %b",
                                 got.px, got.py, got.pz, got.nx, got.ny, got.nz,
                                 got.kept, got.eom);
                        $display("  expected pos %h %h %h nrm %h %h %h kept %b eom %b",
                                 want.px, want.py, want.pz, want.nx, want.ny, want.nz,
                                 want.kept, want.eom);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_COL0;
        cfg_data       = '0;
        mismatch_count = 0;
        sent_count     = 0;
        result_count   = 0;
        kept_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mat_reg[REG_COL0]  = COL0_RST;
        mat_reg[REG_COL1]  = COL1_RST;
        mat_reg[REG_COL2]  = COL2_RST;
        mat_reg[REG_SHIFT] = SHIFT_RST;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_phase(300, 0, 0);
        test_random_phase(250, 60, 0);
        test_random_phase(250, 0, 60);
        test_random_phase(250, 38, 38);
        test_random_phase(50, 0, 0);
        drain();

        $display("Covered %0d vertices, %0d results, %0d with the normal kept,",
                 sent_count, result_count, kept_count);
        $display("over reset, extreme and random matrices with sender and receiver idling.");
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
